/* rtl/crv_pkg.sv */
// Shared types, constants and CRC step function for the calibration record validator.
package crv_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CRC_STAGES = 8;

  localparam logic [CRC_W-1:0]   CRC_INIT       = 16'hFFFF;
  localparam logic [CRC_W-1:0]   CRC_POLY       = 16'h1021;
  localparam logic [WORD_W-1:0]  UNITY_BITS     = 32'h3F80_0000;
  localparam logic [WORD_W-1:0]  MAGIC_RESET    = 32'h0000_0000;
  localparam logic [LIMIT_W-1:0] GAIN_LOW_RESET = 31'h3F00_0000;
  localparam logic [LIMIT_W-1:0] GAIN_HIGH_RESET = 31'h4000_0000;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_MAGIC = 2'd1,
    STATUS_BAD_CRC   = 2'd2,
    STATUS_BAD_GAIN  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC     = 2'd0,
    CFG_GAIN_LOW  = 2'd1,
    CFG_GAIN_HIGH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] record_magic;
    logic [WORD_W-1:0] record_gain_bits;
    logic [WORD_W-1:0] record_checksum;
  } rec_t;

  typedef struct packed {
    status_t           status;
    logic              record_valid;
    logic [WORD_W-1:0] gain_used_bits;
    logic [CRC_W-1:0]  computed_crc;
  } res_t;

  // pipeline payload: record, running crc, checks done at entry
  typedef struct packed {
    logic [WORD_W-1:0] magic;
    logic [WORD_W-1:0] gain;
    logic [WORD_W-1:0] checksum;
    logic [CRC_W-1:0]  crc;
    logic              magic_ok;
    logic              gain_ok;
  } pipe_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crv_stream_if.sv */
// Valid/ready stream interface carrying one item per handshake.
interface crv_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/crv_crc_stage.sv */
// One pipeline stage folding one record byte into the running CRC.
module crv_crc_stage #(
  parameter int unsigned BYTE_IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          d_vld,
  input  crv_pkg::pipe_t d,
  output logic          q_vld,
  output crv_pkg::pipe_t q
);
  import crv_pkg::*;

  logic [7:0] data_byte;
  pipe_t      q_next;

  generate
    if (BYTE_IDX < 4) begin : g_magic
      assign data_byte = d.magic[8*BYTE_IDX +: 8];
    end else begin : g_gain
      assign data_byte = d.gain[8*(BYTE_IDX-4) +: 8];
    end
  endgenerate

  always_comb begin
    q_next     = d;
    q_next.crc = crc_byte(d.crc, data_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else if (en) begin
      q_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end
endmodule

/* rtl/crv_check.sv */
// Final stage: checksum compare, status priority and registered result.
module crv_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          d_vld,
  input  crv_pkg::pipe_t d,
  output logic          q_vld,
  output crv_pkg::res_t q
);
  import crv_pkg::*;

  res_t    q_next;
  status_t st;

  always_comb begin
    if (!d.magic_ok) begin
      st = STATUS_BAD_MAGIC;
    end else if (d.checksum != {{(WORD_W-CRC_W){1'b0}}, d.crc}) begin
      st = STATUS_BAD_CRC;
    end else if (!d.gain_ok) begin
      st = STATUS_BAD_GAIN;
    end else begin
      st = STATUS_OK;
    end
    q_next.status         = st;
    q_next.record_valid   = (st == STATUS_OK);
    q_next.gain_used_bits = (st == STATUS_OK) ? d.gain : UNITY_BITS;
    q_next.computed_crc   = d.crc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else if (en) begin
      q_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end
endmodule

/* rtl/calibration_record_validator.sv */
// Top level of the calibration record validator: config registers and pipeline.
//
// Usage: records arrive on rec (valid/ready, one item per handshake) holding
// magic, gain bits and stored checksum. Each record yields one result on res
// with status, record_valid, gain_used_bits and the computed CRC-16.
// Pipeline: an entry compare of magic and gain range, eight CRC stages of one
// byte each (magic bytes low first, then gain bytes), and a result register.
// One record per cycle is accepted while res is taken or holds no result.
// A stall on res freezes the whole pipeline in place; rec.ready is low only
// while a result is held at the output and res.ready is low.
// Configuration: cfg_wen with cfg_index 0 magic, 1 gain low limit, 2 gain
// high limit; other indexes are ignored. Write only while the pipe is empty.
// Reset (rst, synchronous) empties the pipeline and restores magic 0 and the
// gain limits 0.5 and 2.0.
module calibration_record_validator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [crv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crv_pkg::WORD_W-1:0]       cfg_data,
  crv_stream_if.sink                       rec,
  crv_stream_if.source                     res
);
  import crv_pkg::*;

  logic [WORD_W-1:0]  expected_magic;
  logic [LIMIT_W-1:0] gain_low_bits;
  logic [LIMIT_W-1:0] gain_high_bits;

  logic  adv;
  pipe_t entry;
  logic  stg_vld [CRC_STAGES+1];
  pipe_t stg     [CRC_STAGES+1];
  logic  [CRC_STAGES-1:0] vld_vec;
  rec_t  rec_item;
  res_t  res_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= MAGIC_RESET;
      gain_low_bits  <= GAIN_LOW_RESET;
      gain_high_bits <= GAIN_HIGH_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_MAGIC:     expected_magic <= cfg_data;
        CFG_GAIN_LOW:  gain_low_bits  <= cfg_data[LIMIT_W-1:0];
        CFG_GAIN_HIGH: gain_high_bits <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !res.valid || res.ready;
  assign rec.ready = adv;
  assign rec_item  = rec.data;

  always_comb begin
    entry.magic    = rec_item.record_magic;
    entry.gain     = rec_item.record_gain_bits;
    entry.checksum = rec_item.record_checksum;
    entry.crc      = CRC_INIT;
    entry.magic_ok = (rec_item.record_magic == expected_magic);
    entry.gain_ok  = !rec_item.record_gain_bits[WORD_W-1]
                     && (rec_item.record_gain_bits[LIMIT_W-1:0] >= gain_low_bits)
                     && (rec_item.record_gain_bits[LIMIT_W-1:0] <= gain_high_bits);
  end

  assign stg_vld[0] = rec.valid;
  assign stg[0]     = entry;

  generate
    for (genvar i = 0; i < CRC_STAGES; i++) begin : g_crc
      crv_crc_stage #(
        .BYTE_IDX (i)
      ) u_stage (
        .clk   (clk),
        .rst   (rst),
        .en    (adv),
        .d_vld (stg_vld[i]),
        .d     (stg[i]),
        .q_vld (stg_vld[i+1]),
        .q     (stg[i+1])
      );
      assign vld_vec[i] = stg_vld[i+1];
    end
  endgenerate

  crv_check u_check (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .d_vld (stg_vld[CRC_STAGES]),
    .d     (stg[CRC_STAGES]),
    .q_vld (res.valid),
    .q     (res_item)
  );

  assign res.data = res_item;

`ifndef SYNTHESIS
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld_vec))
    else $error("pipeline valid bits moved during a stall");

  a_fail_unity: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res_item.status != STATUS_OK) |->
      !res_item.record_valid && (res_item.gain_used_bits == UNITY_BITS))
    else $error("rejected record did not report unity gain");

  a_ok_positive: assert property (@(posedge clk) disable iff (rst)
    res.valid && res_item.record_valid |->
      (res_item.status == STATUS_OK) && !res_item.gain_used_bits[WORD_W-1])
    else $error("accepted record carries a negative gain");
`endif
endmodule
